FILE: sv/ocpd_pkg.sv
// shared types, constants and register map of the optical coin pulse detector
package ocpd_pkg;

   // fixed field widths
   localparam int SAMPLE_W = 12;
   localparam int FRAC_W   = 16;
   localparam int BASE_W   = SAMPLE_W + FRAC_W;
   localparam int TIME_W   = 32;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;

   // default group size
   localparam int GROUP_SIZE_DEF = 16;

   // register reset values
   localparam logic [11:0] LOW_LIMIT_RST  = 12'd100;
   localparam logic [11:0] HIGH_LIMIT_RST = 12'd4000;
   localparam logic [11:0] DIP_THR_RST    = 12'd50;
   localparam logic [15:0] DIP_MAX_RST    = 16'd200;
   localparam logic [23:0] HOLD_RST       = 24'd5000;
   localparam logic [15:0] GAIN_RST       = 16'd655;

   typedef enum logic [2:0] {
      REG_LOW_LIMIT  = 3'd0,
      REG_HIGH_LIMIT = 3'd1,
      REG_DIP_THR    = 3'd2,
      REG_DIP_MAX    = 3'd3,
      REG_HOLD       = 3'd4,
      REG_GAIN       = 3'd5,
      REG_SPARE6     = 3'd6,
      REG_SPARE7     = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_BLOCK = 2'd0,
      ST_IDLE  = 2'd1,
      ST_DIP   = 2'd2,
      ST_END   = 2'd3
   } det_state_type;

   typedef struct packed {
      logic [11:0] low_limit;
      logic [11:0] high_limit;
      logic [11:0] dip_threshold;
      logic [15:0] dip_max_ms;
      logic [23:0] hold_ms;
      logic [15:0] smoothing_gain;
   } cfg_type;

   typedef struct packed {
      logic                coin_pulse;
      logic                average_valid;
      logic [SAMPLE_W-1:0] group_average;
      det_state_type       detect_state;
   } det_result_type;

endpackage

FILE: sv/ocpd_req_if.sv
// input channel: photodiode sample, time stamp and tracking enable
interface ocpd_req_if;
   logic                               valid;
   logic                               ready;
   logic [ocpd_pkg::SAMPLE_W-1:0]      sample;
   logic [ocpd_pkg::TIME_W-1:0]        time_ms;
   logic                               track_enable;

   modport source (output valid, sample, time_ms, track_enable, input ready);
   modport sink   (input valid, sample, time_ms, track_enable, output ready);
endinterface

FILE: sv/ocpd_rsp_if.sv
// result channel: coin flag, average and detector state
interface ocpd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               coin_pulse;
   logic                               average_valid;
   logic [ocpd_pkg::SAMPLE_W-1:0]      group_average;
   logic [1:0]                         detect_state;

   modport source (output valid, coin_pulse, average_valid, group_average, detect_state,
                   input ready);
   modport sink   (input valid, coin_pulse, average_valid, group_average, detect_state,
                   output ready);
endinterface

FILE: sv/ocpd_detect.sv
// dip detector state machine and q12.16 baseline tracker
module ocpd_detect (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  logic                                grp,
   input  logic [ocpd_pkg::SAMPLE_W-1:0]       avg,
   input  logic [ocpd_pkg::TIME_W-1:0]         now,
   input  logic                                track_en,
   input  ocpd_pkg::cfg_type                   cfg,
   output ocpd_pkg::det_result_type            res
);

   localparam int SW = ocpd_pkg::SAMPLE_W;
   localparam int FW = ocpd_pkg::FRAC_W;
   localparam int BW = ocpd_pkg::BASE_W;
   localparam int TW = ocpd_pkg::TIME_W;

   ocpd_pkg::det_state_type state_ff, state_in;
   logic [BW-1:0]           baseline_ff, baseline_in;
   logic                    seeded_ff;
   logic [TW-1:0]           dip_start_ff;
   logic [TW-1:0]           block_until_ff;
   logic [SW-1:0]           prev_avg_ff;

   logic [BW-1:0]   base_eff;
   logic [SW-1:0]   base_int;
   logic            outside;
   logic            dip_now;
   logic            rise_now;
   logic [TW-1:0]   blk_elapsed;
   logic            blk_done;
   logic [TW-1:0]   dip_len;
   logic            dip_long;
   logic [TW-1:0]   hold_end;
   logic            hit;
   logic            load_block;
   logic            load_dip;
   logic            upd;
   logic [BW:0]     delta;
   logic            neg;
   logic [BW:0]     delta_abs;
   logic [BW+FW-1:0] prod;
   logic [BW+FW-1:0] prod_rnd;
   logic [BW-1:0]   stepv;
   logic [BW-1:0]   base_new;

   // first average seeds the baseline
   assign base_eff = seeded_ff ? baseline_ff : {avg, {FW{1'b0}}};
   assign base_int = base_eff[BW-1 -: SW];

   assign outside = (base_eff < {cfg.low_limit, {FW{1'b0}}})
                 || (base_eff > {cfg.high_limit, {FW{1'b0}}})
                 || (avg < cfg.low_limit) || (avg > cfg.high_limit);

   assign dip_now  = ({1'b0, avg} + {1'b0, cfg.dip_threshold}) < {1'b0, base_int};
   assign rise_now = {1'b0, avg} > ({1'b0, prev_avg_ff} + {1'b0, cfg.dip_threshold});

   // wrap safe time compares
   assign blk_elapsed = now - block_until_ff;
   assign blk_done    = ~blk_elapsed[TW-1];
   assign dip_len     = now - dip_start_ff;
   assign dip_long    = dip_len > {16'b0, cfg.dip_max_ms};
   assign hold_end    = now + {8'b0, cfg.hold_ms};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ocpd_pkg::ST_BLOCK: begin
            if (!outside && blk_done) state_in = ocpd_pkg::ST_IDLE;
         end
         ocpd_pkg::ST_IDLE: begin
            priority if (outside) state_in = ocpd_pkg::ST_BLOCK;
            else if (dip_now)     state_in = ocpd_pkg::ST_DIP;
            else                  state_in = ocpd_pkg::ST_IDLE;
         end
         ocpd_pkg::ST_DIP: begin
            priority if (rise_now) state_in = ocpd_pkg::ST_END;
            else if (dip_long)     state_in = ocpd_pkg::ST_BLOCK;
            else                   state_in = ocpd_pkg::ST_DIP;
         end
         ocpd_pkg::ST_END: begin
            state_in = ocpd_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      hit        = 1'b0;
      load_block = 1'b0;
      load_dip   = 1'b0;
      unique case (state_ff)
         ocpd_pkg::ST_BLOCK: load_block = outside;
         ocpd_pkg::ST_IDLE: begin
            load_block = outside;
            load_dip   = !outside && dip_now;
         end
         ocpd_pkg::ST_DIP:   load_block = !rise_now && dip_long;
         ocpd_pkg::ST_END:   hit = 1'b1;
      endcase
   end

   // baseline step: round(gain * delta / 2^16), ties away from zero
   assign upd       = track_en && ((state_in == ocpd_pkg::ST_IDLE)
                                || (state_in == ocpd_pkg::ST_BLOCK));
   assign delta     = {1'b0, avg, {FW{1'b0}}} - {1'b0, base_eff};
   assign neg       = delta[BW];
   assign delta_abs = neg ? (~delta + 1'b1) : delta;
   assign prod      = delta_abs[BW-1:0] * cfg.smoothing_gain;
   assign prod_rnd  = prod + (BW+FW)'(32768);
   assign stepv     = prod_rnd[FW +: BW];
   assign base_new  = neg ? (base_eff - stepv) : (base_eff + stepv);
   assign baseline_in = upd ? base_new : base_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ocpd_pkg::ST_IDLE;
         baseline_ff    <= '0;
         seeded_ff      <= 1'b0;
         dip_start_ff   <= '0;
         block_until_ff <= '0;
         prev_avg_ff    <= '0;
      end else if (fire && grp) begin
         state_ff    <= state_in;
         baseline_ff <= baseline_in;
         seeded_ff   <= 1'b1;
         prev_avg_ff <= avg;
         if (load_block) block_until_ff <= hold_end;
         if (load_dip)   dip_start_ff   <= now;
      end
   end

   assign res.coin_pulse    = grp && hit;
   assign res.average_valid = grp;
   assign res.group_average = grp ? avg : prev_avg_ff;
   assign res.detect_state  = grp ? state_in : state_ff;

endmodule

FILE: sv/optical_coin_pulse_detector_core.sv
// top level of the optical coin pulse detector: channels, registers, accumulator, pipeline
//
// Photodiode samples are summed in groups of GROUP_SIZE; the transfer that closes a group
// yields the floor average, which drives a four-state dip detector (blocking, idle, dip
// started, dip ended) against a q12.16 exponential baseline seeded by the first average.
// Every input transfer gives exactly one result transfer, in order. The path is a
// three-register pipeline (input/accumulate, average by reciprocal multiply, detector and
// baseline multiply-add) that takes one item per cycle unless the result channel stalls;
// each result passes through all three registers before its transfer. The whole
// pipeline advances together, so req ready follows
// whether the output register is free or being drained. Registers sit on the apb-style
// port at byte addresses 0, 4, ... 20 and should only be written while nothing is in flight.
module optical_coin_pulse_detector_core #(
   parameter int GROUP_SIZE = ocpd_pkg::GROUP_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ocpd_req_if.sink                       req_ch,
   ocpd_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ocpd_pkg::ADDR_W-1:0]    paddr,
   input  logic [ocpd_pkg::DATA_W-1:0]    pwdata,
   output logic [ocpd_pkg::DATA_W-1:0]    prdata,
   output logic                           pready
);

   localparam int SW     = ocpd_pkg::SAMPLE_W;
   localparam int TW     = ocpd_pkg::TIME_W;
   localparam int LOG_G  = $clog2(GROUP_SIZE);
   localparam int SUM_W  = SW + LOG_G;
   localparam int CNT_W  = (LOG_G > 0) ? LOG_G : 1;
   // exact floor division by a constant: q = (sum * m) >> (SUM_W + LOG_G)
   localparam int DIV_SH = SUM_W + LOG_G;
   localparam logic [63:0] DIV_M_FULL =
      ((64'd1 << DIV_SH) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE);
   localparam logic [SUM_W:0] DIV_M = DIV_M_FULL[SUM_W:0];
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GROUP_SIZE - 1);

   // register file
   ocpd_pkg::cfg_type     cfg_ff;
   ocpd_pkg::reg_idx_type csr_idx;
   logic                  csr_wr;

   // accumulator
   logic [SUM_W-1:0] acc_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [SUM_W-1:0] sum_total;
   logic             grp_end;

   // pipeline stage one: input register
   logic             s1_v_ff;
   logic [SUM_W-1:0] s1_sum_ff;
   logic             s1_grp_ff;
   logic [TW-1:0]    s1_time_ff;
   logic             s1_en_ff;

   // pipeline stage two: average
   logic              s2_v_ff;
   logic [SW-1:0]     s2_avg_ff;
   logic              s2_grp_ff;
   logic [TW-1:0]     s2_time_ff;
   logic              s2_en_ff;
   logic [2*SUM_W:0]  div_prod;

   // output register
   logic                     rsp_v_ff;
   ocpd_pkg::det_result_type rsp_ff;
   ocpd_pkg::det_result_type det_res;

   logic advance;
   logic req_xfer;

   // whole pipeline moves when the output register is empty or drained
   assign advance      = !rsp_v_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign req_xfer     = req_ch.valid && advance;

   // ---------------- configuration port ----------------
   assign pready  = 1'b1;
   assign csr_idx = ocpd_pkg::reg_idx_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_limit      <= ocpd_pkg::LOW_LIMIT_RST;
         cfg_ff.high_limit     <= ocpd_pkg::HIGH_LIMIT_RST;
         cfg_ff.dip_threshold  <= ocpd_pkg::DIP_THR_RST;
         cfg_ff.dip_max_ms     <= ocpd_pkg::DIP_MAX_RST;
         cfg_ff.hold_ms        <= ocpd_pkg::HOLD_RST;
         cfg_ff.smoothing_gain <= ocpd_pkg::GAIN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            ocpd_pkg::REG_LOW_LIMIT:  cfg_ff.low_limit      <= pwdata[11:0];
            ocpd_pkg::REG_HIGH_LIMIT: cfg_ff.high_limit     <= pwdata[11:0];
            ocpd_pkg::REG_DIP_THR:    cfg_ff.dip_threshold  <= pwdata[11:0];
            ocpd_pkg::REG_DIP_MAX:    cfg_ff.dip_max_ms     <= pwdata[15:0];
            ocpd_pkg::REG_HOLD:       cfg_ff.hold_ms        <= pwdata[23:0];
            ocpd_pkg::REG_GAIN:       cfg_ff.smoothing_gain <= pwdata[15:0];
            default: ;  // unmapped addresses ignore writes
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         ocpd_pkg::REG_LOW_LIMIT:  prdata = {20'b0, cfg_ff.low_limit};
         ocpd_pkg::REG_HIGH_LIMIT: prdata = {20'b0, cfg_ff.high_limit};
         ocpd_pkg::REG_DIP_THR:    prdata = {20'b0, cfg_ff.dip_threshold};
         ocpd_pkg::REG_DIP_MAX:    prdata = {16'b0, cfg_ff.dip_max_ms};
         ocpd_pkg::REG_HOLD:       prdata = {8'b0, cfg_ff.hold_ms};
         ocpd_pkg::REG_GAIN:       prdata = {16'b0, cfg_ff.smoothing_gain};
         default:                  prdata = '0;
      endcase
   end

   // ---------------- group accumulator ----------------
   assign sum_total = acc_ff + SUM_W'(req_ch.sample);
   assign grp_end   = (cnt_ff == CNT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (req_xfer) begin
         if (grp_end) begin
            acc_ff <= '0;
            cnt_ff <= '0;
         end else begin
            acc_ff <= sum_total;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- stage one ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_sum_ff  <= sum_total;
         s1_grp_ff  <= grp_end;
         s1_time_ff <= req_ch.time_ms;
         s1_en_ff   <= req_ch.track_enable;
      end
   end

   // ---------------- stage two: divide by group size ----------------
   assign div_prod = s1_sum_ff * DIV_M;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (advance) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_v_ff) begin
         s2_avg_ff  <= div_prod[DIV_SH +: SW];
         s2_grp_ff  <= s1_grp_ff;
         s2_time_ff <= s1_time_ff;
         s2_en_ff   <= s1_en_ff;
      end
   end

   // ---------------- stage three: detector and baseline ----------------
   ocpd_detect u_detect (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance && s2_v_ff),
      .grp      (s2_grp_ff),
      .avg      (s2_avg_ff),
      .now      (s2_time_ff),
      .track_en (s2_en_ff),
      .cfg      (cfg_ff),
      .res      (det_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (advance) begin
         rsp_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_v_ff) begin
         rsp_ff <= det_res;
      end
   end

   // result transfer
   assign rsp_ch.valid         = rsp_v_ff;
   assign rsp_ch.coin_pulse    = rsp_ff.coin_pulse;
   assign rsp_ch.average_valid = rsp_ff.average_valid;
   assign rsp_ch.group_average = rsp_ff.group_average;
   assign rsp_ch.detect_state  = rsp_ff.detect_state;

endmodule
